@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that cond never holds at a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/cba_pkg.sv @@
// ----------------------------------------------------------------------------
// Consensus base accumulator package
// Request codes, entry layout, field widths and saturating arithmetic.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int POS_W   = 12;
    localparam int BASE_W  = 8;
    localparam int SCORE_W = 32;
    localparam int CFG_W   = 13;

    // Reset length of the alignment
    localparam logic [CFG_W-1:0] ALIGN_LENGTH_RESET = 13'd4096;

    // Character code of the unknown base 'N'
    localparam logic [BASE_W-1:0] BASE_UNKNOWN = 8'd78;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_MERGE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    // One consensus table entry, base in the lowest bits
    typedef struct packed {
        logic [SCORE_W-1:0] link;
        logic [SCORE_W-1:0] score;
        logic [BASE_W-1:0]  base;
    } entry_t;

    // Unsigned add that clamps at all ones
    function automatic logic [SCORE_W-1:0] sat_add(
        input logic [SCORE_W-1:0] a,
        input logic [SCORE_W-1:0] b
    );
        logic [SCORE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        sat_add = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
    endfunction

endpackage

@@ rtl/core/consensus_base_accumulator.sv @@
// A read request enters the request stage as its entry is read; its result is then registered
// on m_tdata. Throughput: one request per cycle while s_tready is high; the table is read on
// accept and written back the next cycle, with the last write forwarded to the following request.
// s_tready drops only during reset and while a finished read result waits on the output
// and a further read is held behind it. Reset clears control state and sets align_length
// to 4096; the table contents are undefined until loaded, with no clearing pass.
// ----------------------------------------------------------------------------
// Consensus base accumulator
// Per-position consensus table of base, score and link weight, updated by
// load and merge requests and returned by read requests.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module consensus_base_accumulator
    import cba_pkg::*;
#(
    parameter int MAX_LENGTH = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,     // align_length

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [87:0]      s_tdata,       // position, base, base_score, link_weight, zero pad
    input  logic [1:0]       s_tuser,       // action

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,       // out_base, out_score, out_link
    output logic             m_tlast        // last
);

    localparam int AW    = $clog2(MAX_LENGTH);
    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam logic [CMP_W-1:0] MAX_LEN_C = CMP_W'(MAX_LENGTH);

    // Configuration
    logic [CFG_W-1:0] align_length_reg;
    logic [CMP_W-1:0] align_ext;
    logic [CMP_W-1:0] len_eff;

    // Request stage holding the item whose entry is being read
    logic               s1_valid_reg, s1_valid_next;
    action_t            s1_action_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic [BASE_W-1:0]  s1_base_reg;
    logic [SCORE_W-1:0] s1_score_reg;
    logic [SCORE_W-1:0] s1_link_reg;

    // Table memory and write-back forwarding
    entry_t             mem [MAX_LENGTH];
    entry_t             rd_data_reg;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0]      fwd_addr_reg;
    entry_t             fwd_data_reg;

    // Output slot
    logic               m_tvalid_reg, m_tvalid_next;
    logic [71:0]        m_tdata_reg;
    logic               m_tlast_reg;

    logic               advance;
    logic               accept;
    logic [CMP_W-1:0]   in_pos_ext;
    logic [AW-1:0]      rd_addr;
    logic [CMP_W-1:0]   s1_pos_ext;
    logic [AW-1:0]      s1_addr;
    logic               in_range;
    logic               is_last;
    logic               s1_is_read;
    entry_t             old_entry;
    entry_t             new_entry;
    logic               mem_we;

    // Clamp the configured length to 1 .. MAX_LENGTH
    assign align_ext = CMP_W'(align_length_reg);
    always_comb begin
        priority if (align_length_reg == '0) begin
            len_eff = CMP_W'(1);
        end else if (align_ext > MAX_LEN_C) begin
            len_eff = MAX_LEN_C;
        end else begin
            len_eff = align_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_length_reg <= ALIGN_LENGTH_RESET;
        end else if (cfg_we) begin
            align_length_reg <= cfg_wdata;
        end
    end

    // Hold the request stage only while a read result cannot leave
    assign s1_is_read = s1_valid_reg && (s1_action_reg == ACT_READ);
    assign advance    = !(s1_is_read && m_tvalid_reg && !m_tready);
    assign s_tready   = advance && aresetn;
    assign accept     = s_tvalid && s_tready;

    assign in_pos_ext = CMP_W'(s_tdata[POS_W-1:0]);
    assign rd_addr    = in_pos_ext[AW-1:0];
    assign s1_pos_ext = CMP_W'(s1_pos_reg);
    assign s1_addr    = s1_pos_ext[AW-1:0];
    assign in_range   = s1_pos_ext < len_eff;
    assign is_last    = s1_pos_ext == (len_eff - CMP_W'(1));

    // Advance the request stage
    assign s1_valid_next = advance ? s_tvalid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_action_reg <= action_t'(s_tuser);
            s1_pos_reg    <= s_tdata[11:0];
            s1_base_reg   <= s_tdata[19:12];
            s1_score_reg  <= s_tdata[51:20];
            s1_link_reg   <= s_tdata[83:52];
        end
    end

    // Take the entry just written when the read raced with it
    assign old_entry = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_data_reg
                                                                     : rd_data_reg;

    // Build the updated entry
    always_comb begin
        new_entry = old_entry;
        unique case (s1_action_reg)
            ACT_LOAD: begin
                new_entry.base  = s1_base_reg;
                new_entry.score = s1_score_reg;
                new_entry.link  = s1_link_reg;
            end
            ACT_MERGE: begin
                priority if (old_entry.base == s1_base_reg) begin
                    new_entry.score = sat_add(old_entry.score, s1_score_reg);
                end else if (old_entry.score >= s1_score_reg) begin
                    if (old_entry.base == BASE_UNKNOWN) begin
                        new_entry.base  = s1_base_reg;
                        new_entry.score = '0;
                    end else begin
                        new_entry.score = old_entry.score - s1_score_reg;
                    end
                end else begin
                    new_entry.base  = s1_base_reg;
                    new_entry.score = s1_score_reg - old_entry.score;
                end
                if (!is_last) begin
                    new_entry.link = sat_add(old_entry.link, s1_link_reg);
                end
            end
            default: begin
                new_entry = old_entry;
            end
        endcase
    end

    assign mem_we = advance && s1_valid_reg && in_range &&
                    ((s1_action_reg == ACT_LOAD) || (s1_action_reg == ACT_MERGE));

    // Table memory: write back, read for the newly accepted request
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[s1_addr] <= new_entry;
        end
        if (accept) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track the last write for forwarding
    assign fwd_valid_next = advance ? mem_we : fwd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= new_entry;
        end
    end

    // Output slot: load a read result, drop it once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        priority if (advance && s1_is_read) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_is_read) begin
            if (in_range) begin
                m_tdata_reg <= {old_entry.link, old_entry.score, old_entry.base};
                m_tlast_reg <= is_last;
            end else begin
                m_tdata_reg <= '0;
                m_tlast_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Backpressure only comes from a read blocked behind a full output slot
    `ASSERT_CLK(a_stall_cause, aclk, aresetn, !s_tready |-> (s1_is_read && m_tvalid_reg))
    // A read leaving the request stage fills the output slot
    `ASSERT_CLK(a_read_to_out, aclk, aresetn, (advance && s1_is_read) |=> m_tvalid_reg)
    // Table writes come only from a valid request
    `ASSERT_NEVER(a_write_idle, aclk, aresetn, mem_we && !s1_valid_reg)
    // Every write is offered for forwarding to the next request
    `ASSERT_CLK(a_fwd_follows, aclk, aresetn, mem_we |=> fwd_valid_reg)

endmodule
